FILE: hw/rtl/smrr_pkg.sv
// Shared types and constants of the ranged SplitMix64 generator.
`default_nettype none
package smrr_pkg;

	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 64;
	localparam logic [0:0]  REG_SEED   = 1'b0;

	localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
	localparam int unsigned SHIFT_1    = 30;
	localparam int unsigned SHIFT_2    = 27;
	localparam int unsigned SHIFT_3    = 31;
	localparam int unsigned FRAC_SHIFT = 11;

	localparam logic [1:0] OP_RAW   = 2'd0;
	localparam logic [1:0] OP_FRAC  = 2'd1;
	localparam logic [1:0] OP_RANGE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_LARGE = 2'd2;

	localparam int unsigned DIV_CNT_W = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd63;

	// datapath commands
	localparam logic [3:0] CMD_NONE   = 4'd0;
	localparam logic [3:0] CMD_LOAD   = 4'd1;
	localparam logic [3:0] CMD_CHECK  = 4'd2;
	localparam logic [3:0] CMD_ADV    = 4'd3;
	localparam logic [3:0] CMD_MUL_LL = 4'd4;
	localparam logic [3:0] CMD_MUL_LH = 4'd5;
	localparam logic [3:0] CMD_MUL_HL = 4'd6;
	localparam logic [3:0] CMD_XS     = 4'd7;
	localparam logic [3:0] CMD_FIN    = 4'd8;
	localparam logic [3:0] CMD_DIV    = 4'd9;
	localparam logic [3:0] CMD_EMIT   = 4'd10;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [63:0] range_low;
		logic signed [63:0] range_high;
	} req_word_t;

	typedef struct packed {
		logic [63:0]        random_bits;
		logic [52:0]        unit_fraction;
		logic signed [63:0] ranged_value;
		logic [1:0]         status;
		logic [63:0]        state_value;
	} rsp_word_t;

	typedef struct packed {
		logic [3:0] code;
		logic       const_b;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_range;
		logic range_err;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/smrr_stream_if.sv
// Valid/ready stream channel carrying one word.
`default_nettype none
interface smrr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/splitmix64_ranged_random.sv
// Top level of the ranged SplitMix64 random word generator.
// Usage:
//   req channel: operation (raw, fraction, range) with range_low/range_high.
//   rsp channel: random_bits, unit_fraction, ranged_value, status, state_value.
//   APB port: one 64-bit seed register at byte address 0; a write reloads the
//   running state, reads return the seed. Write only while the block is idle.
// Steps per word, from acceptance to the result register:
//   load, range check, state advance, two mix multiplies, finish, and for
//   range mode the modulo; a rejected range goes from the check to the result.
//   A new request is taken the cycle after the result is loaded, not before.
//   The two mix multiplies each take three passes through one 32x32
//   multiplier; range mode adds a 64-step restoring modulo by span + 1.
// Stalls: the result sits in an output register; the next request is
//   accepted while it waits, and its result is held back until the register
//   is taken.
// Reset: seed and state clear to zero, no word pending.
`default_nettype none
module splitmix64_ranged_random (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	smrr_stream_if.sink                                req,
	smrr_stream_if.source                              rsp,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [smrr_pkg::APB_ADDR_W-1:0]       paddr,
	input  wire logic [smrr_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [smrr_pkg::APB_DATA_W-1:0]            prdata,
	output logic                                       pready
);
	import smrr_pkg::*;

	ctrl_cmd_t   cmd;
	dp_stat_t    stat;
	logic        seed_we;
	logic [63:0] seed;

	assign pready  = 1'b1;
	assign prdata  = seed;
	assign seed_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1:3] == REG_SEED);

	smrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	smrr_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_word   (req.payload),
		.rsp_word   (rsp.payload),
		.seed_we    (seed_we),
		.seed_wdata (pwdata),
		.seed       (seed)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.payload.status == ST_OK ||
			(rsp.payload.random_bits == '0 && rsp.payload.ranged_value == '0)))
		else $error("rejected range word carries nonzero data");

	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.payload.unit_fraction == rsp.payload.random_bits[63:FRAC_SHIFT])
		else $error("fraction does not match word");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result appeared while idle");

endmodule
`default_nettype wire

FILE: hw/rtl/smrr_ctrl.sv
// Sequencing state machine of the generator.
`default_nettype none
module smrr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	input  wire smrr_pkg::dp_stat_t   stat,
	output smrr_pkg::ctrl_cmd_t       cmd
);
	import smrr_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_ADV   = 4'd2;
	localparam logic [3:0] S_M1A   = 4'd3;
	localparam logic [3:0] S_M1B   = 4'd4;
	localparam logic [3:0] S_M1C   = 4'd5;
	localparam logic [3:0] S_XS    = 4'd6;
	localparam logic [3:0] S_M2A   = 4'd7;
	localparam logic [3:0] S_M2B   = 4'd8;
	localparam logic [3:0] S_M2C   = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;
	localparam logic [3:0] S_DIV   = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;

	logic [3:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 emit;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || rsp_ready);

	always_comb begin
		state_d     = state_q;
		cmd.code    = CMD_NONE;
		cmd.const_b = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.code = CMD_LOAD;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.code = CMD_CHECK;
				state_d  = stat.range_err ? S_EMIT : S_ADV;
			end
			S_ADV: begin
				cmd.code = CMD_ADV;
				state_d  = S_M1A;
			end
			S_M1A: begin
				cmd.code = CMD_MUL_LL;
				state_d  = S_M1B;
			end
			S_M1B: begin
				cmd.code = CMD_MUL_LH;
				state_d  = S_M1C;
			end
			S_M1C: begin
				cmd.code = CMD_MUL_HL;
				state_d  = S_XS;
			end
			S_XS: begin
				cmd.code = CMD_XS;
				state_d  = S_M2A;
			end
			S_M2A: begin
				cmd.code    = CMD_MUL_LL;
				cmd.const_b = 1'b1;
				state_d     = S_M2B;
			end
			S_M2B: begin
				cmd.code    = CMD_MUL_LH;
				cmd.const_b = 1'b1;
				state_d     = S_M2C;
			end
			S_M2C: begin
				cmd.code    = CMD_MUL_HL;
				cmd.const_b = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				cmd.code = CMD_FIN;
				state_d  = stat.is_range ? S_DIV : S_EMIT;
			end
			S_DIV: begin
				cmd.code = CMD_DIV;
				if (cnt_q == DIV_LAST) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (emit) begin
					cmd.code = CMD_EMIT;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (emit) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/smrr_datapath.sv
// Generator state, mixer with shared 32x32 multiplier, and bit-serial modulo.
`default_nettype none
module smrr_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire smrr_pkg::ctrl_cmd_t  cmd,
	output smrr_pkg::dp_stat_t        stat,
	input  wire smrr_pkg::req_word_t  req_word,
	output smrr_pkg::rsp_word_t       rsp_word,
	input  wire logic                 seed_we,
	input  wire logic [63:0]          seed_wdata,
	output logic [63:0]               seed
);
	import smrr_pkg::*;

	logic [63:0]        seed_q, state_q;
	logic [1:0]         op_q;
	logic signed [63:0] lo_q, hi_q;
	logic [63:0]        dvs_q;
	logic [1:0]         status_q;
	logic [63:0]        z_q, acc_q, word_q, dvd_q, rem_q;
	rsp_word_t          out_q;

	logic               is_range, lt, ok;
	logic [63:0]        span, adv, fin, mul_c;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        prod;
	logic [64:0]        rem_sh;
	logic               ge;

	assign seed     = seed_q;
	assign rsp_word = out_q;

	assign is_range       = (op_q == OP_RANGE);
	assign lt             = hi_q < lo_q;
	assign span           = hi_q - lo_q;
	assign stat.is_range  = is_range;
	assign stat.range_err = is_range && (lt || span[63]);

	assign adv   = state_q + GOLDEN_INC;
	assign fin   = acc_q ^ (acc_q >> SHIFT_3);
	assign mul_c = cmd.const_b ? MIX_MUL_B : MIX_MUL_A;
	assign mul_a = (cmd.code == CMD_MUL_HL) ? z_q[63:32] : z_q[31:0];
	assign mul_b = (cmd.code == CMD_MUL_LH) ? mul_c[63:32] : mul_c[31:0];
	assign prod  = 64'(mul_a) * 64'(mul_b);

	assign rem_sh = {rem_q, dvd_q[63]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign ok     = (status_q == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			state_q <= '0;
		end else if (seed_we) begin
			seed_q  <= seed_wdata;
			state_q <= seed_wdata;
		end else if (cmd.code == CMD_ADV) begin
			state_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_LOAD: begin
				op_q <= req_word.operation;
				lo_q <= req_word.range_low;
				hi_q <= req_word.range_high;
			end
			CMD_CHECK: begin
				dvs_q <= span + 64'd1;
				if (!is_range) status_q <= ST_OK;
				else if (lt) status_q <= ST_EMPTY;
				else if (span[63]) status_q <= ST_LARGE;
				else status_q <= ST_OK;
			end
			CMD_ADV:    z_q   <= adv ^ (adv >> SHIFT_1);
			CMD_MUL_LL: acc_q <= prod;
			CMD_MUL_LH: acc_q <= acc_q + {prod[31:0], 32'd0};
			CMD_MUL_HL: acc_q <= acc_q + {prod[31:0], 32'd0};
			CMD_XS:     z_q   <= acc_q ^ (acc_q >> SHIFT_2);
			CMD_FIN: begin
				word_q <= fin;
				dvd_q  <= fin;
				rem_q  <= '0;
			end
			CMD_DIV: begin
				dvd_q <= {dvd_q[62:0], 1'b0};
				rem_q <= ge ? 64'(rem_sh - {1'b0, dvs_q}) : rem_sh[63:0];
			end
			CMD_EMIT: begin
				out_q.random_bits   <= ok ? word_q : '0;
				out_q.unit_fraction <= ok ? word_q[63:FRAC_SHIFT] : '0;
				out_q.ranged_value  <= (ok && is_range) ? lo_q + rem_q : '0;
				out_q.status        <= status_q;
				out_q.state_value   <= state_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
